// ===== sv/impact_pulse_click_voice_core_macros.svh =====
// Assertion macros shared by the impact voice RTL.
// Used by modules that declare clk and rst_n; no other dependencies.
`ifndef IMPACT_PULSE_CLICK_VOICE_CORE_MACROS_SVH
`define IMPACT_PULSE_CLICK_VOICE_CORE_MACROS_SVH

// Same-cycle implication, checked out of reset
`define IPCV_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define IPCV_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/ipcv_pkg.sv =====
// Shared types, constants and fixed-point helpers for the impact voice.
// No dependencies; the other files, the macro header apart, refer to it by scoped names.
package ipcv_pkg;

    // Sample width of the rendered outputs
    localparam int SAMPLE_BITS = 32;
    localparam int OUT_BITS    = (SAMPLE_BITS < 32) ? SAMPLE_BITS : 32;

    localparam int DATA_W = 32;
    localparam int LEN_W  = 16;
    localparam int THR_W  = 31;
    localparam int IDX_W  = 1;

    // Digit-serial multiplier geometry
    localparam int DIGIT_W   = 4;
    localparam int MUL_A_W   = DATA_W + 1;
    localparam int MUL_B_W   = DATA_W;
    localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
    localparam int MUL_STEPS = MUL_B_W / DIGIT_W;
    localparam int CNT_W     = $clog2(MUL_STEPS);
    localparam int PP_W      = MUL_A_W + DIGIT_W + 1;
    localparam int HI_W      = PP_W - DIGIT_W;
    localparam int ACC_W     = MUL_P_W + 1;

    localparam logic signed [DATA_W-1:0] ONE_Q30   = 32'sh4000_0000;
    localparam logic signed [DATA_W-1:0] SAT_MAX   = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] SAT_MIN   = 32'sh8000_0000;
    localparam longint                   OUT_MAX   = (longint'(1) << (OUT_BITS - 1)) - 1;
    localparam longint                   OUT_MIN   = -OUT_MAX - 1;

    // Configuration register indexes and reset values
    localparam logic [IDX_W-1:0] REG_OUT_GAIN        = 1'b0;
    localparam logic [IDX_W-1:0] REG_DRAIN_THRESHOLD = 1'b1;
    localparam logic signed [DATA_W-1:0] OUT_GAIN_RESET  = 32'sh0100_0000;
    localparam logic [THR_W-1:0]         DRAIN_THR_RESET = 31'd1;

    typedef enum logic [1:0] {
        SH_24,
        SH_30,
        SH_31
    } shift_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] out_gain;
        logic [THR_W-1:0]         drain_threshold;
    } cfg_t;

    typedef struct packed {
        logic                     operation;
        logic signed [DATA_W-1:0] rot_re;
        logic signed [DATA_W-1:0] rot_im;
        logic [LEN_W-1:0]         pulse_samples;
        logic signed [DATA_W-1:0] pulse_height;
        logic signed [DATA_W-1:0] accel_amp;
        logic signed [DATA_W-1:0] click_b0;
        logic signed [DATA_W-1:0] click_a1;
        logic signed [DATA_W-1:0] click_a2;
    } item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] force_sample;
        logic signed [DATA_W-1:0] click_sample;
        logic                     voice_busy;
    } result_t;

    typedef struct packed {
        logic                      start;
        logic signed [MUL_A_W-1:0] a;
        logic signed [MUL_B_W-1:0] b;
    } mul_req_t;

    typedef struct packed {
        logic                      done;
        logic signed [MUL_P_W-1:0] product;
    } mul_rsp_t;

    // Saturate a 34-bit sum to 32 signed bits
    function automatic logic signed [DATA_W-1:0] sat34(input logic signed [DATA_W+1:0] v);
        logic signed [DATA_W-1:0] r;
        if (v > (DATA_W+2)'(SAT_MAX))
            r = SAT_MAX;
        else if (v < (DATA_W+2)'(SAT_MIN))
            r = SAT_MIN;
        else
            r = v[DATA_W-1:0];
        return r;
    endfunction

    // Round to nearest (ties up) by the selected shift, then saturate
    function automatic logic signed [DATA_W-1:0] round_sat(input logic signed [ACC_W-1:0] acc,
                                                           input shift_t sh);
        logic signed [ACC_W-1:0] t;
        logic signed [ACC_W-1:0] q;
        logic signed [DATA_W-1:0] r;
        case (sh)
            SH_30:
            begin
                t = acc + (ACC_W'(1) <<< 29);
                q = t >>> 30;
            end
            SH_31:
            begin
                t = acc + (ACC_W'(1) <<< 30);
                q = t >>> 31;
            end
            default:
            begin
                t = acc + (ACC_W'(1) <<< 23);
                q = t >>> 24;
            end
        endcase
        if (q > ACC_W'(SAT_MAX))
            r = SAT_MAX;
        else if (q < ACC_W'(SAT_MIN))
            r = SAT_MIN;
        else
            r = q[DATA_W-1:0];
        return r;
    endfunction

    // Limit a phasor step to [-1.0, +1.0] in Q1.30
    function automatic logic signed [DATA_W-1:0] clamp_unit(input logic signed [DATA_W-1:0] v);
        logic signed [DATA_W-1:0] r;
        if (v > ONE_Q30)
            r = ONE_Q30;
        else if (v < -ONE_Q30)
            r = -ONE_Q30;
        else
            r = v;
        return r;
    endfunction

    // Saturate an output sample to the rendered sample width
    function automatic logic signed [DATA_W-1:0] sat_out(input logic signed [DATA_W-1:0] v);
        longint vl;
        logic signed [DATA_W-1:0] r;
        vl = longint'(v);
        if (vl > OUT_MAX)
            r = DATA_W'(OUT_MAX);
        else if (vl < OUT_MIN)
            r = DATA_W'(OUT_MIN);
        else
            r = v;
        return r;
    endfunction

    // Magnitude of a 32-bit signed value
    function automatic logic [DATA_W:0] abs33(input logic signed [DATA_W-1:0] v);
        logic signed [DATA_W:0] e;
        logic [DATA_W:0] r;
        e = (DATA_W+1)'(v);
        if (v[DATA_W-1])
            r = -e;
        else
            r = e;
        return r;
    endfunction

endpackage

// ===== sv/ipcv_if.sv =====
// Request and result channel interfaces of the impact voice.
// Depends on ipcv_pkg for field widths.
interface ipcv_item_if;
    logic                               valid;
    logic                               ready;
    logic                               operation;
    logic signed [ipcv_pkg::DATA_W-1:0] rot_re;
    logic signed [ipcv_pkg::DATA_W-1:0] rot_im;
    logic [ipcv_pkg::LEN_W-1:0]         pulse_samples;
    logic signed [ipcv_pkg::DATA_W-1:0] pulse_height;
    logic signed [ipcv_pkg::DATA_W-1:0] accel_amp;
    logic signed [ipcv_pkg::DATA_W-1:0] click_b0;
    logic signed [ipcv_pkg::DATA_W-1:0] click_a1;
    logic signed [ipcv_pkg::DATA_W-1:0] click_a2;

    modport source (
        output valid, operation, rot_re, rot_im, pulse_samples, pulse_height,
               accel_amp, click_b0, click_a1, click_a2,
        input  ready
    );
    modport sink (
        input  valid, operation, rot_re, rot_im, pulse_samples, pulse_height,
               accel_amp, click_b0, click_a1, click_a2,
        output ready
    );
endinterface

interface ipcv_result_if;
    logic                               valid;
    logic                               ready;
    logic signed [ipcv_pkg::DATA_W-1:0] force_sample;
    logic signed [ipcv_pkg::DATA_W-1:0] click_sample;
    logic                               voice_busy;

    modport source (
        output valid, force_sample, click_sample, voice_busy,
        input  ready
    );
    modport sink (
        input  valid, force_sample, click_sample, voice_busy,
        output ready
    );
endinterface

// ===== sv/ipcv_mul.sv =====
// Digit-serial signed multiplier: one 4-bit digit of b per cycle.
// Depends on ipcv_pkg for widths and the request/response structs.
module ipcv_mul (
    input  logic               clk,
    input  logic               rst_n,
    input  ipcv_pkg::mul_req_t req,
    output ipcv_pkg::mul_rsp_t rsp
);

    logic signed [ipcv_pkg::MUL_A_W-1:0] a_reg;
    logic [ipcv_pkg::MUL_B_W-1:0]        b_reg;
    logic signed [ipcv_pkg::HI_W-1:0]    hi_reg;
    logic [ipcv_pkg::MUL_B_W-1:0]        lo_reg;
    logic [ipcv_pkg::CNT_W-1:0]          count_reg;
    logic                                busy_reg;
    logic                                done_reg;

    logic                                last;
    logic signed [ipcv_pkg::DIGIT_W:0]   digit;
    logic signed [ipcv_pkg::PP_W-1:0]    partial;
    logic signed [ipcv_pkg::PP_W-1:0]    sum;

    // Low digits are unsigned, the top digit carries the sign of b
    assign last    = (count_reg == ipcv_pkg::CNT_W'(ipcv_pkg::MUL_STEPS - 1));
    assign digit   = {last & b_reg[ipcv_pkg::DIGIT_W-1], b_reg[ipcv_pkg::DIGIT_W-1:0]};
    assign partial = a_reg * digit;
    assign sum     = ipcv_pkg::PP_W'(hi_reg) + partial;

    // Sequence control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            done_reg <= busy_reg & last;
            if (req.start)
            begin
                busy_reg  <= 1'b1;
                count_reg <= '0;
            end
            else if (busy_reg)
            begin
                count_reg <= count_reg + ipcv_pkg::CNT_W'(1);
                if (last)
                    busy_reg <= 1'b0;
            end
        end
    end

    // Accumulate one digit, shift finished low bits out
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            a_reg  <= req.a;
            b_reg  <= req.b;
            hi_reg <= '0;
            lo_reg <= '0;
        end
        else if (busy_reg)
        begin
            hi_reg <= sum[ipcv_pkg::PP_W-1:ipcv_pkg::DIGIT_W];
            lo_reg <= {sum[ipcv_pkg::DIGIT_W-1:0],
                       lo_reg[ipcv_pkg::MUL_B_W-1:ipcv_pkg::DIGIT_W]};
            b_reg  <= b_reg >> ipcv_pkg::DIGIT_W;
        end
    end

    assign rsp.done    = done_reg;
    assign rsp.product = {hi_reg[ipcv_pkg::MUL_A_W-1:0], lo_reg};

endmodule

// ===== sv/ipcv_core.sv =====
// Voice sequencer and datapath: phasor, force pulse, recoil filter, drain test.
// Depends on ipcv_pkg, ipcv_mul and the assertion macro header.
`include "impact_pulse_click_voice_core_macros.svh"

module ipcv_core (
    input  logic              clk,
    input  logic              rst_n,
    input  ipcv_pkg::cfg_t    cfg,
    input  logic              item_valid,
    output logic              item_ready,
    input  ipcv_pkg::item_t   item,
    output logic              res_valid,
    input  logic              res_take,
    output ipcv_pkg::result_t res
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_ISSUE  = 7'b0000010,
        S_WAIT   = 7'b0000100,
        S_ROUND  = 7'b0001000,
        S_WRITE  = 7'b0010000,
        S_FINISH = 7'b0100000,
        S_DONE   = 7'b1000000
    } state_t;

    typedef enum logic [3:0] {
        OP_PR_SR,
        OP_PI_SI,
        OP_PR_SI,
        OP_PI_SR,
        OP_FORCE,
        OP_DRIVE,
        OP_FEED,
        OP_FB_ONE,
        OP_FB_TWO,
        OP_CLICK
    } op_t;

    typedef enum logic [1:0] {
        ACC_LOAD,
        ACC_ADD,
        ACC_SUB
    } acc_mode_t;

    state_t state_reg, state_next;
    op_t    op_reg, op_next;
    logic   held_reg, held_next;
    logic [ipcv_pkg::LEN_W-1:0] samples_reg, samples_next;
    logic   mul_start;

    // Voice state
    logic signed [ipcv_pkg::DATA_W-1:0] pr_reg, pi_reg, sr_reg, si_reg;
    logic signed [ipcv_pkg::DATA_W-1:0] peak_reg, drive_reg, feed_reg, fb_one_reg, fb_two_reg;
    logic signed [ipcv_pkg::DATA_W-1:0] z1_reg, z2_reg;

    // Working values
    logic signed [ipcv_pkg::ACC_W-1:0]  acc_reg;
    logic signed [ipcv_pkg::DATA_W-1:0] rnd_reg, re_tmp_reg, force_reg, u_reg, bu_reg;
    logic signed [ipcv_pkg::DATA_W-1:0] y_reg, click_reg;
    ipcv_pkg::result_t                  res_reg;

    logic signed [ipcv_pkg::MUL_A_W-1:0] mul_a;
    logic signed [ipcv_pkg::MUL_B_W-1:0] mul_b;
    acc_mode_t                           acc_mode;
    logic                                op_writes;
    ipcv_pkg::shift_t                    shift;
    logic signed [ipcv_pkg::DATA_W-1:0]  y_comb;
    logic signed [ipcv_pkg::MUL_A_W-1:0] one_minus_re;
    logic [ipcv_pkg::DATA_W+1:0]         drain_sum;
    logic                                drained;

    ipcv_pkg::mul_req_t mul_req;
    ipcv_pkg::mul_rsp_t mul_rsp;

    ipcv_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .rsp   (mul_rsp)
    );

    assign y_comb       = ipcv_pkg::sat34((ipcv_pkg::DATA_W+2)'(bu_reg)
                                          + (ipcv_pkg::DATA_W+2)'(z1_reg));
    assign one_minus_re = ipcv_pkg::MUL_A_W'(ipcv_pkg::ONE_Q30)
                          - ipcv_pkg::MUL_A_W'(pr_reg);
    assign drain_sum    = (ipcv_pkg::DATA_W+2)'(ipcv_pkg::abs33(z1_reg))
                          + (ipcv_pkg::DATA_W+2)'(ipcv_pkg::abs33(z2_reg));
    assign drained      = (samples_reg == '0)
                          && (drain_sum < (ipcv_pkg::DATA_W+2)'(cfg.drain_threshold));

    // Operand routing and rounding per micro-op
    always_comb
    begin
        mul_a     = '0;
        mul_b     = '0;
        acc_mode  = ACC_LOAD;
        op_writes = 1'b1;
        shift     = ipcv_pkg::SH_24;
        case (op_reg)
            OP_PR_SR:
            begin
                mul_a     = ipcv_pkg::MUL_A_W'(pr_reg);
                mul_b     = sr_reg;
                op_writes = 1'b0;
            end
            OP_PI_SI:
            begin
                mul_a    = ipcv_pkg::MUL_A_W'(pi_reg);
                mul_b    = si_reg;
                acc_mode = ACC_SUB;
                shift    = ipcv_pkg::SH_30;
            end
            OP_PR_SI:
            begin
                mul_a     = ipcv_pkg::MUL_A_W'(pr_reg);
                mul_b     = si_reg;
                op_writes = 1'b0;
            end
            OP_PI_SR:
            begin
                mul_a    = ipcv_pkg::MUL_A_W'(pi_reg);
                mul_b    = sr_reg;
                acc_mode = ACC_ADD;
                shift    = ipcv_pkg::SH_30;
            end
            OP_FORCE:
            begin
                mul_a = one_minus_re;
                mul_b = peak_reg;
                shift = ipcv_pkg::SH_31;
            end
            OP_DRIVE:
            begin
                mul_a = ipcv_pkg::MUL_A_W'(drive_reg);
                mul_b = force_reg;
            end
            OP_FEED:
            begin
                mul_a = ipcv_pkg::MUL_A_W'(feed_reg);
                mul_b = u_reg;
            end
            OP_FB_ONE:
            begin
                mul_a = ipcv_pkg::MUL_A_W'(y_comb);
                mul_b = fb_one_reg;
            end
            OP_FB_TWO:
            begin
                mul_a = ipcv_pkg::MUL_A_W'(y_reg);
                mul_b = fb_two_reg;
            end
            OP_CLICK:
            begin
                mul_a = ipcv_pkg::MUL_A_W'(y_reg);
                mul_b = cfg.out_gain;
            end
            default:
            begin
                op_writes = 1'b0;
            end
        endcase
    end

    assign mul_req.start = mul_start;
    assign mul_req.a     = mul_a;
    assign mul_req.b     = mul_b;

    // Sequencer next state
    always_comb
    begin
        state_next   = state_reg;
        op_next      = op_reg;
        held_next    = held_reg;
        samples_next = samples_reg;
        mul_start    = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    if (item.operation)
                    begin
                        if (!held_reg && (item.pulse_samples != '0))
                        begin
                            held_next    = 1'b1;
                            samples_next = item.pulse_samples;
                        end
                    end
                    else if (!held_reg)
                        state_next = S_DONE;
                    else
                    begin
                        state_next = S_ISSUE;
                        op_next    = (samples_reg != '0) ? OP_PR_SR : OP_DRIVE;
                    end
                end
            end
            S_ISSUE:
            begin
                mul_start  = 1'b1;
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (mul_rsp.done)
                begin
                    if (op_writes)
                        state_next = S_ROUND;
                    else
                    begin
                        state_next = S_ISSUE;
                        op_next    = op_t'(op_reg + 4'd1);
                    end
                end
            end
            S_ROUND:
            begin
                state_next = S_WRITE;
            end
            S_WRITE:
            begin
                if (op_reg == OP_FORCE)
                    samples_next = samples_reg - ipcv_pkg::LEN_W'(1);
                if (op_reg == OP_CLICK)
                    state_next = S_FINISH;
                else
                begin
                    state_next = S_ISSUE;
                    op_next    = op_t'(op_reg + 4'd1);
                end
            end
            S_FINISH:
            begin
                if (drained)
                    held_next = 1'b0;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (res_take)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            op_reg      <= OP_PR_SR;
            held_reg    <= 1'b0;
            samples_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            op_reg      <= op_next;
            held_reg    <= held_next;
            samples_reg <= samples_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    // Load a strike into a free voice
                    if (item.operation && !held_reg && (item.pulse_samples != '0))
                    begin
                        pr_reg     <= ipcv_pkg::ONE_Q30;
                        pi_reg     <= '0;
                        sr_reg     <= ipcv_pkg::clamp_unit(item.rot_re);
                        si_reg     <= ipcv_pkg::clamp_unit(item.rot_im);
                        peak_reg   <= item.pulse_height;
                        drive_reg  <= item.accel_amp;
                        feed_reg   <= item.click_b0;
                        fb_one_reg <= item.click_a1;
                        fb_two_reg <= item.click_a2;
                        z1_reg     <= '0;
                        z2_reg     <= '0;
                    end
                    // Idle tick emits silence
                    if (!item.operation && !held_reg)
                        res_reg <= '0;
                    // Pulse over: no force, filter keeps draining
                    if (!item.operation && held_reg && (samples_reg == '0))
                        force_reg <= '0;
                end
            end
            S_ISSUE:
            begin
                if (op_reg == OP_FB_ONE)
                    y_reg <= y_comb;
            end
            S_WAIT:
            begin
                if (mul_rsp.done)
                begin
                    case (acc_mode)
                        ACC_ADD: acc_reg <= acc_reg + ipcv_pkg::ACC_W'(mul_rsp.product);
                        ACC_SUB: acc_reg <= acc_reg - ipcv_pkg::ACC_W'(mul_rsp.product);
                        default: acc_reg <= ipcv_pkg::ACC_W'(mul_rsp.product);
                    endcase
                end
            end
            S_ROUND:
            begin
                rnd_reg <= ipcv_pkg::round_sat(acc_reg, shift);
            end
            S_WRITE:
            begin
                case (op_reg)
                    OP_PI_SI: re_tmp_reg <= rnd_reg;
                    OP_PI_SR:
                    begin
                        pr_reg <= re_tmp_reg;
                        pi_reg <= rnd_reg;
                    end
                    OP_FORCE:  force_reg <= rnd_reg;
                    OP_DRIVE:  u_reg     <= rnd_reg;
                    OP_FEED:   bu_reg    <= rnd_reg;
                    OP_FB_ONE: z1_reg    <= ipcv_pkg::sat34((ipcv_pkg::DATA_W+2)'(z2_reg)
                                                            - (ipcv_pkg::DATA_W+2)'(rnd_reg));
                    OP_FB_TWO: z2_reg    <= ipcv_pkg::sat34(-(ipcv_pkg::DATA_W+2)'(bu_reg)
                                                            - (ipcv_pkg::DATA_W+2)'(rnd_reg));
                    OP_CLICK:  click_reg <= rnd_reg;
                    default:   ;
                endcase
            end
            S_FINISH:
            begin
                res_reg.force_sample <= ipcv_pkg::sat_out(force_reg);
                res_reg.click_sample <= ipcv_pkg::sat_out(click_reg);
                res_reg.voice_busy   <= held_next;
            end
            S_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    assign item_ready = (state_reg == S_IDLE);
    assign res_valid  = (state_reg == S_DONE);
    assign res        = res_reg;

    // Checks on the sequencer
    `IPCV_ASSERT_NOW(a_done_in_wait, mul_rsp.done, state_reg == S_WAIT, "product arrived outside wait")
    `IPCV_ASSERT_NOW(a_force_has_sample, (state_reg == S_WRITE) && (op_reg == OP_FORCE), samples_reg != '0, "force step with no pulse left")
    `IPCV_ASSERT_NEXT(a_strike_no_result, item_valid && item_ready && item.operation, state_reg == S_IDLE, "strike did not return to idle")
    `IPCV_ASSERT_NOW(a_busy_tracks_held, state_reg == S_DONE, res.voice_busy == held_reg, "busy flag differs from voice hold")

endmodule

// ===== sv/impact_pulse_click_voice_core.sv =====
// Top level of the impact voice: configuration registers and output register.
// Depends on ipcv_pkg, ipcv_if and ipcv_core.
// Each tick puts one result in the output register, a strike none; a stalled output holds
// the core in its done state. A request is taken only while the core is idle (strikes: one
// per cycle), so a tick waits for the previous result; a tick on a held voice runs ten (or
// five, once the pulse is over) 8-digit serial products. Reset: async low, voice free.
module impact_pulse_click_voice_core (
    input  logic                         clk,
    input  logic                         rst_n,
    ipcv_item_if.sink                    item,
    ipcv_result_if.source                result,
    input  logic                         wr_en,
    input  logic [ipcv_pkg::IDX_W-1:0]   wr_index,
    input  logic [ipcv_pkg::DATA_W-1:0]  wr_data
);

    logic signed [ipcv_pkg::DATA_W-1:0] out_gain_reg;
    logic [ipcv_pkg::THR_W-1:0]         drain_threshold_reg;
    ipcv_pkg::cfg_t                     cfg;
    ipcv_pkg::item_t                    item_data;
    ipcv_pkg::result_t                  res;
    ipcv_pkg::result_t                  out_data_reg;
    logic                               out_valid_reg;
    logic                               res_valid;
    logic                               res_take;
    logic                               item_ready;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_gain_reg        <= ipcv_pkg::OUT_GAIN_RESET;
            drain_threshold_reg <= ipcv_pkg::DRAIN_THR_RESET;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                ipcv_pkg::REG_OUT_GAIN:        out_gain_reg        <= wr_data;
                ipcv_pkg::REG_DRAIN_THRESHOLD: drain_threshold_reg <= wr_data[ipcv_pkg::THR_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg.out_gain        = out_gain_reg;
    assign cfg.drain_threshold = drain_threshold_reg;

    // Gather the request payload
    assign item_data.operation     = item.operation;
    assign item_data.rot_re        = item.rot_re;
    assign item_data.rot_im        = item.rot_im;
    assign item_data.pulse_samples = item.pulse_samples;
    assign item_data.pulse_height  = item.pulse_height;
    assign item_data.accel_amp     = item.accel_amp;
    assign item_data.click_b0      = item.click_b0;
    assign item_data.click_a1      = item.click_a1;
    assign item_data.click_a2      = item.click_a2;
    assign item.ready              = item_ready;

    ipcv_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .item_valid (item.valid),
        .item_ready (item_ready),
        .item       (item_data),
        .res_valid  (res_valid),
        .res_take   (res_take),
        .res        (res)
    );

    // Output register: take a result when the slot is free or draining
    assign res_take = res_valid && (!out_valid_reg || result.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (res_take)
            out_valid_reg <= 1'b1;
        else if (result.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
            out_data_reg <= res;
    end

    assign result.valid        = out_valid_reg;
    assign result.force_sample = out_data_reg.force_sample;
    assign result.click_sample = out_data_reg.click_sample;
    assign result.voice_busy   = out_data_reg.voice_busy;

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for impact_pulse_click_voice_core: an in-bench voice predictor
// checks every rendered sample. Depends on ipcv_pkg, ipcv_if and the core RTL.
module testbench;

    typedef ipcv_pkg::item_t   req_t;
    typedef ipcv_pkg::result_t smp_t;

    localparam logic OP_TICK   = 1'b0;
    localparam logic OP_STRIKE = 1'b1;

    localparam logic signed [31:0] Q_MAX   = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q_MIN   = 32'sh8000_0000;
    localparam logic signed [31:0] Q24_ONE = 32'sh0100_0000;
    localparam logic signed [31:0] Q30_ONE = 32'sh4000_0000;
    localparam real                TWO_PI  = 6.283185307179586;

    localparam int     SETTLE_CYCLES = 130;
    localparam longint RUN_LIMIT     = 64'd50_000_000;

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           wr_en;
    logic [ipcv_pkg::IDX_W-1:0]     wr_index;
    logic [ipcv_pkg::DATA_W-1:0]    wr_data;

    ipcv_item_if   req_bus ();
    ipcv_result_if sample_bus ();

    impact_pulse_click_voice_core i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .item     (req_bus),
        .result   (sample_bus),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    // Voice shadow state and register copies
    bit     voice_on;
    longint rot_acc_re, rot_acc_im, rot_step_re, rot_step_im;
    longint pulse_left, pulse_gamma, accel_gain;
    longint fir_b0, fb_a1, fb_a2, recoil_z1, recoil_z2;
    longint gain_cfg, drain_cfg;

    smp_t pending_samples[$];
    int   counted_requests;
    int   mismatches;
    int   send_idle_pct;
    int   recv_stall_pct;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Stall the result channel at the current rate
    always @(posedge clk)
    begin
        sample_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    initial
    begin
        #(RUN_LIMIT);
        $display("FAIL");
        $finish;
    end

    // ---------------------------------------------------------------- predictor

    function automatic longint round_shift_q(input longint v, input int sh);
        return (v + (longint'(1) <<< (sh - 1))) >>> sh;
    endfunction

    function automatic longint clip32(input longint v);
        return (v > longint'(Q_MAX)) ? longint'(Q_MAX) :
               ((v < longint'(Q_MIN)) ? longint'(Q_MIN) : v);
    endfunction

    function automatic longint qmul24(input longint a, input longint b);
        return clip32(round_shift_q(a * b, 24));
    endfunction

    function automatic longint clip_unit(input longint v);
        return (v > longint'(Q30_ONE)) ? longint'(Q30_ONE) :
               ((v < -longint'(Q30_ONE)) ? -longint'(Q30_ONE) : v);
    endfunction

    function automatic logic signed [31:0] clip_to_sample(input longint v);
        longint c;
        c = (v > ipcv_pkg::OUT_MAX) ? ipcv_pkg::OUT_MAX :
            ((v < ipcv_pkg::OUT_MIN) ? ipcv_pkg::OUT_MIN : v);
        return 32'(c);
    endfunction

    // Advance the voice by one accepted request; queue the sample it renders
    function automatic void advance_voice(input req_t req);
        longint nre, nim, frc, u, bu, y, nz1, nz2, mag;
        smp_t   s;
        frc = 0;
        if (req.operation == OP_STRIKE)
        begin
            if (voice_on || req.pulse_samples == 0)
                return;
            voice_on    = 1'b1;
            rot_acc_re  = longint'(Q30_ONE);
            rot_acc_im  = 0;
            rot_step_re = clip_unit(longint'(signed'(req.rot_re)));
            rot_step_im = clip_unit(longint'(signed'(req.rot_im)));
            pulse_left  = longint'(req.pulse_samples);
            pulse_gamma = longint'(signed'(req.pulse_height));
            accel_gain  = longint'(signed'(req.accel_amp));
            fir_b0      = longint'(signed'(req.click_b0));
            fb_a1       = longint'(signed'(req.click_a1));
            fb_a2       = longint'(signed'(req.click_a2));
            recoil_z1   = 0;
            recoil_z2   = 0;
            counted_requests++;
            return;
        end
        counted_requests++;
        if (!voice_on)
        begin
            s = '0;
            pending_samples.insert(pending_samples.size(), s);
            return;
        end
        // Rotate the phasor and shape the raised-cosine force
        if (pulse_left > 0)
        begin
            nre = clip32(round_shift_q(rot_acc_re * rot_step_re - rot_acc_im * rot_step_im, 30));
            nim = clip32(round_shift_q(rot_acc_re * rot_step_im + rot_acc_im * rot_step_re, 30));
            rot_acc_re = nre;
            rot_acc_im = nim;
            frc = clip32(round_shift_q(pulse_gamma * (longint'(Q30_ONE) - rot_acc_re), 31));
            pulse_left--;
        end
        // Recoil filter, transposed second-order section
        u   = qmul24(accel_gain, frc);
        bu  = qmul24(fir_b0, u);
        y   = clip32(bu + recoil_z1);
        nz1 = clip32(recoil_z2 - qmul24(fb_a1, y));
        nz2 = clip32(-bu - qmul24(fb_a2, y));
        recoil_z1 = nz1;
        recoil_z2 = nz2;
        mag = (recoil_z1 < 0 ? -recoil_z1 : recoil_z1) + (recoil_z2 < 0 ? -recoil_z2 : recoil_z2);
        if (pulse_left == 0 && mag < drain_cfg)
            voice_on = 1'b0;
        s.force_sample = clip_to_sample(frc);
        s.click_sample = clip_to_sample(qmul24(y, gain_cfg));
        s.voice_busy   = voice_on;
        pending_samples.insert(pending_samples.size(), s);
    endfunction

    // ------------------------------------------------------------------ checker

    function automatic void flag_mismatch(input string what, input logic signed [31:0] want,
                                          input logic signed [31:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch on %s: expected %0d, got %0d", what, want, got);
    endfunction

    // Compare each accepted sample with the oldest prediction
    always @(posedge clk)
    begin
        smp_t want;
        if (rst_n === 1'b1 && sample_bus.valid === 1'b1 && sample_bus.ready === 1'b1)
        begin
            if (pending_samples.size() == 0)
                flag_mismatch("unexpected sample", 0, sample_bus.force_sample);
            else
            begin
                want = pending_samples.pop_front();
                if (sample_bus.force_sample !== want.force_sample)
                    flag_mismatch("force_sample", want.force_sample, sample_bus.force_sample);
                if (sample_bus.click_sample !== want.click_sample)
                    flag_mismatch("click_sample", want.click_sample, sample_bus.click_sample);
                if (sample_bus.voice_busy !== want.voice_busy)
                    flag_mismatch("voice_busy", 32'(want.voice_busy), 32'(sample_bus.voice_busy));
            end
        end
    end

    // ------------------------------------------------------------------ drivers

    // Offer one request, hold it until accepted, then idle at the current rate
    task automatic send_request(input req_t req);
        req_bus.valid         <= 1'b1;
        req_bus.operation     <= req.operation;
        req_bus.rot_re        <= req.rot_re;
        req_bus.rot_im        <= req.rot_im;
        req_bus.pulse_samples <= req.pulse_samples;
        req_bus.pulse_height  <= req.pulse_height;
        req_bus.accel_amp     <= req.accel_amp;
        req_bus.click_b0      <= req.click_b0;
        req_bus.click_a1      <= req.click_a1;
        req_bus.click_a2      <= req.click_a2;
        @(posedge clk);
        while (req_bus.ready !== 1'b1)
            @(posedge clk);
        advance_voice(req);
        if ($urandom_range(99) < send_idle_pct)
        begin
            req_bus.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
    endtask

    // Drop valid, wait for every predicted sample, then let the core go quiet
    task automatic settle();
        req_bus.valid <= 1'b0;
        while (pending_samples.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [ipcv_pkg::IDX_W-1:0] index,
                                  input logic [31:0] data);
        settle();
        wr_en    <= 1'b1;
        wr_index <= index;
        wr_data  <= data;
        @(posedge clk);
        wr_en <= 1'b0;
        if (index == ipcv_pkg::REG_OUT_GAIN)
            gain_cfg = longint'(signed'(data));
        else if (index == ipcv_pkg::REG_DRAIN_THRESHOLD)
            drain_cfg = longint'(data[30:0]);
        @(posedge clk);
    endtask

    // ------------------------------------------------------------------ stimulus

    function automatic logic signed [31:0] spread(input int mag);
        return int'($urandom_range(0, 2 * mag)) - mag;
    endfunction

    function automatic req_t random_fields();
        req_t r;
        r.operation     = 1'($urandom);
        r.rot_re        = $urandom;
        r.rot_im        = $urandom;
        r.pulse_samples = 16'($urandom_range(0, 65535));
        r.pulse_height  = $urandom;
        r.accel_amp     = $urandom;
        r.click_b0      = $urandom;
        r.click_a1      = $urandom;
        r.click_a2      = $urandom;
        return r;
    endfunction

    function automatic req_t tick_req();
        req_t r;
        r = random_fields();
        r.operation = OP_TICK;
        return r;
    endfunction

    function automatic req_t strike(input int len, input logic signed [31:0] re, im,
                                    input logic signed [31:0] h, d, b0, a1, a2);
        req_t r;
        r.operation     = OP_STRIKE;
        r.pulse_samples = 16'(len);
        r.rot_re        = re;
        r.rot_im        = im;
        r.pulse_height  = h;
        r.accel_amp     = d;
        r.click_b0      = b0;
        r.click_a1      = a1;
        r.click_a2      = a2;
        return r;
    endfunction

    // Well-formed strike: usually one phasor turn over the pulse, stable recoil filter
    function automatic req_t pulse_strike();
        req_t   r;
        int     len;
        real    w;
        longint a2v, lim;
        r = random_fields();
        r.operation = OP_STRIKE;
        len = $urandom_range(1, 40);
        r.pulse_samples = 16'(len);
        w = TWO_PI / len;
        if ($urandom_range(9) != 0)
        begin
            r.rot_re = int'($cos(w) * 1073741824.0);
            r.rot_im = int'($sin(w) * 1073741824.0);
        end
        r.pulse_height = spread(1 << 26);
        r.accel_amp    = spread(1 << 26);
        r.click_b0     = spread(1 << 24);
        a2v = longint'(spread(12582912));
        lim = ((longint'(Q24_ONE) + a2v) * 9) / 10;
        r.click_a1 = spread(int'(lim));
        r.click_a2 = 32'(a2v);
        return r;
    endfunction

    // Full-range strike whose filter is either pure feed or pure feedback
    function automatic req_t wide_strike();
        req_t r;
        r = random_fields();
        r.operation     = OP_STRIKE;
        r.pulse_samples = 16'($urandom_range(0, 24));
        if ($urandom_range(1) == 0)
        begin
            r.click_a1 = '0;
            r.click_a2 = '0;
        end
        else
            r.click_b0 = '0;
        return r;
    endfunction

    task automatic tick_until_free(input int limit);
        int n;
        n = 0;
        while (voice_on && n < limit)
        begin
            send_request(tick_req());
            n++;
        end
    endtask

    // ------------------------------------------------------------------ tests

    task automatic test_idle_tick();
        send_request(tick_req());
    endtask

    task automatic test_empty_strike();
        send_request(strike(0, Q30_ONE, 0, Q24_ONE, Q24_ONE, Q24_ONE, 0, 0));
        send_request(tick_req());
    endtask

    task automatic test_basic_pulse();
        send_request(strike(3, -32'sd536870912, 32'sd929887697, Q24_ONE, Q24_ONE,
                            Q24_ONE, 0, 0));
        tick_until_free(8);
    endtask

    task automatic test_strike_while_held();
        send_request(strike(1, Q30_ONE, 0, Q24_ONE, Q24_ONE, Q24_ONE, 0, 0));
        send_request(strike(5, 0, Q30_ONE, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX));
        tick_until_free(8);
    endtask

    // Out-of-range steps get clamped; saturate force, filter and click
    task automatic test_extreme_pulses();
        send_request(strike(2, Q_MAX, Q_MIN, Q_MAX, Q_MAX, Q_MAX, 0, 0));
        tick_until_free(8);
        send_request(strike(2, Q_MIN, Q_MAX, Q_MIN, Q_MIN, Q_MIN, 0, 0));
        tick_until_free(8);
    endtask

    task automatic test_feedback_extremes();
        send_request(strike(1, Q30_ONE, 0, Q_MAX, Q_MAX, 0, Q_MAX, Q_MIN));
        tick_until_free(4);
        send_request(strike(1, Q30_ONE, 0, Q_MIN, Q_MIN, 0, Q_MIN, Q_MAX));
        tick_until_free(4);
    endtask

    // Zero threshold holds the voice; the largest one frees it at once
    task automatic test_drain_threshold();
        write_register(ipcv_pkg::REG_OUT_GAIN, 32'h0000_0000);
        write_register(ipcv_pkg::REG_DRAIN_THRESHOLD, 32'h8000_0000);
        send_request(strike(1, Q30_ONE, 0, Q24_ONE, Q24_ONE, Q24_ONE, 0, 0));
        repeat (4) send_request(tick_req());
        write_register(ipcv_pkg::REG_DRAIN_THRESHOLD, 32'h7FFF_FFFF);
        send_request(tick_req());
    endtask

    task automatic random_phase(input int send_pct, input int stall_pct,
                                input logic [31:0] gain, input int quota);
        int stop_at;
        int held_ticks;
        int pick;
        send_idle_pct  = send_pct;
        recv_stall_pct = stall_pct;
        write_register(ipcv_pkg::REG_OUT_GAIN, gain);
        write_register(ipcv_pkg::REG_DRAIN_THRESHOLD,
                       {1'($urandom), 31'($urandom_range(1 << 10, 1 << 20))});
        stop_at    = counted_requests + quota;
        held_ticks = 0;
        while (counted_requests < stop_at)
        begin
            pick = $urandom_range(99);
            if (pick == 0)
                settle();
            else if (voice_on)
            begin
                if (pick < 10)
                    send_request(random_fields());
                else
                    send_request(tick_req());
                held_ticks++;
                // Force a release if the filter never drains
                if (held_ticks > 1000)
                begin
                    write_register(ipcv_pkg::REG_DRAIN_THRESHOLD, 32'h7FFF_FFFF);
                    held_ticks = 0;
                end
            end
            else
            begin
                held_ticks = 0;
                if (pick < 70)
                    send_request(pulse_strike());
                else if (pick < 85)
                    send_request(wide_strike());
                else
                    send_request(tick_req());
            end
        end
    endtask

    // Longest pulse; the run ends with the voice still held
    task automatic test_long_pulse();
        write_register(ipcv_pkg::REG_DRAIN_THRESHOLD, 32'h7FFF_FFFF);
        tick_until_free(50);
        send_request(strike(65535, 32'sh3FFF_FFFF, 32'sh0000_6488, Q24_ONE, Q24_ONE,
                            Q24_ONE, 0, 0));
        repeat (3) send_request(tick_req());
    endtask

    // ------------------------------------------------------------------ sequence

    initial
    begin
        rst_n                 <= 1'b0;
        wr_en                 <= 1'b0;
        wr_index              <= '0;
        wr_data               <= '0;
        req_bus.valid         <= 1'b0;
        req_bus.operation     <= OP_TICK;
        req_bus.rot_re        <= '0;
        req_bus.rot_im        <= '0;
        req_bus.pulse_samples <= '0;
        req_bus.pulse_height  <= '0;
        req_bus.accel_amp     <= '0;
        req_bus.click_b0      <= '0;
        req_bus.click_a1      <= '0;
        req_bus.click_a2      <= '0;
        send_idle_pct         = 0;
        recv_stall_pct        = 0;
        mismatches            = 0;
        counted_requests      = 0;
        voice_on              = 1'b0;
        rot_acc_re            = longint'(Q30_ONE);
        rot_acc_im            = 0;
        rot_step_re           = 0;
        rot_step_im           = 0;
        pulse_left            = 0;
        pulse_gamma           = 0;
        accel_gain            = 0;
        fir_b0                = 0;
        fb_a1                 = 0;
        fb_a2                 = 0;
        recoil_z1             = 0;
        recoil_z2             = 0;
        gain_cfg              = longint'(ipcv_pkg::OUT_GAIN_RESET);
        drain_cfg             = longint'(ipcv_pkg::DRAIN_THR_RESET);
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_idle_tick();
        test_empty_strike();
        test_basic_pulse();
        test_strike_while_held();
        test_extreme_pulses();
        test_feedback_extremes();
        test_drain_threshold();

        random_phase(0, 0, 32'h7FFF_FFFF, 500);
        random_phase(49, 0, $urandom, 500);
        random_phase(0, 49, 32'h8000_0000, 500);
        random_phase(30, 30, 32'(spread(1 << 25)), 500);

        test_long_pulse();

        settle();
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
